// File: hw/rtl/bgemv_pkg.sv
// Shared constants, codes and types for the banded matrix-vector product core.
// No dependencies; the interfaces and the core refer to it by scoped names, the bench imports it.
package bgemv_pkg;

  localparam int MAX_ORDER      = 1024;
  localparam int MAX_SUB_DIAG   = 4;
  localparam int MAX_SUPER_DIAG = 4;
  localparam int VALUE_W        = 32;
  localparam int FRAC_W         = 24;
  localparam int PROD_W         = 2 * VALUE_W;

  localparam int IDX_W      = 10;  // row / column index field
  localparam int N_W        = 11;  // order register, holds MAX_ORDER itself
  localparam int DIAG_W     = 3;   // sub / super diagonal count registers
  localparam int OP_W       = 3;
  localparam int ERR_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int BAND_ROWS   = MAX_SUB_DIAG + MAX_SUPER_DIAG + 1;
  localparam int BAND_DEPTH  = MAX_ORDER * BAND_ROWS;
  localparam int BAND_AW     = $clog2(BAND_DEPTH);
  localparam int BAND_STRIDE = BAND_ROWS - 1;

  localparam logic signed [VALUE_W-1:0] ONE_Q   = VALUE_W'(1 << FRAC_W);
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_WR_BAND = 3'd0,
    OP_WR_X    = 3'd1,
    OP_WR_Y    = 3'd2,
    OP_COMPUTE = 3'd3,
    OP_RD_Y    = 3'd4
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK   = 2'd0,
    ERR_ADDR = 2'd1,
    ERR_SAT  = 2'd2
  } err_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE  = 3'd0,
    CFG_SUB   = 3'd1,
    CFG_SUPER = 3'd2,
    CFG_ALPHA = 3'd3,
    CFG_BETA  = 3'd4
  } cfg_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    err_e                      error_code;
  } res_t;

endpackage

// File: hw/rtl/bgemv_if.sv
// Handshake channels of the banded matrix-vector product core: command words,
// result words and configuration writes. Depends on bgemv_pkg.
interface bgemv_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [bgemv_pkg::OP_W-1:0]              operation;
  logic [bgemv_pkg::IDX_W-1:0]             row_index;
  logic [bgemv_pkg::IDX_W-1:0]             col_index;
  logic signed [bgemv_pkg::VALUE_W-1:0]    write_value;

  modport source (output valid, operation, row_index, col_index, write_value, input ready);
  modport sink   (input valid, operation, row_index, col_index, write_value, output ready);
endinterface

interface bgemv_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [bgemv_pkg::VALUE_W-1:0]    read_value;
  logic [bgemv_pkg::ERR_W-1:0]             error_code;

  modport source (output valid, read_value, error_code, input ready);
  modport sink   (input valid, read_value, error_code, output ready);
endinterface

interface bgemv_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [bgemv_pkg::CFG_IDX_W-1:0]         index;
  logic [bgemv_pkg::CFG_DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/bgemv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
module bgemv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/banded_matrix_vector_gemv_core.sv
// Banded y = alpha*A*x + beta*y core with one shared 32x32 multiplier.
// Writes and unknown operations: one word per cycle while results drain; a read waits in S_RD_WAIT.
// Compute: y is cleared (beta 0) or scaled by beta (beta neither 0 nor 1.0), then each
// column with a nonzero x element runs the read-multiply-write loop over its band entries.
// Reset clears control and configuration (n=1, kl=ku=0, alpha=1.0, beta=0);
// the band, x and y memories stay undefined until written.
module banded_matrix_vector_gemv_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  bgemv_in_if.sink    in_i,
  bgemv_cfg_if.sink   cfg_i,
  bgemv_out_if.source res_o
);

  localparam int W    = bgemv_pkg::VALUE_W;
  localparam int IW   = bgemv_pkg::IDX_W;
  localparam int NW   = bgemv_pkg::N_W;
  localparam int DW   = bgemv_pkg::DIAG_W;
  localparam int AW   = bgemv_pkg::BAND_AW;
  localparam int PW   = bgemv_pkg::PROD_W;
  localparam int SH_W = PW - bgemv_pkg::FRAC_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_B_CLR, S_B_RD, S_B_MUL, S_B_WR,
    S_X_RD, S_X_CHK, S_T_SAT, S_A_RD, S_A_MUL, S_A_WR, S_FIN
  } state_e;

  // product >> FRAC_W (floor), saturated; returns {overflow, value}
  function automatic logic [W:0] prod_sat(logic signed [PW-1:0] p);
    logic [SH_W-1:0] sh;
    logic            ovf;
    sh  = p[PW-1:bgemv_pkg::FRAC_W];
    ovf = !((&sh[SH_W-1:W-1]) || !(|sh[SH_W-1:W-1]));
    if (ovf) begin
      return {1'b1, (sh[SH_W-1] ? bgemv_pkg::VAL_MIN : bgemv_pkg::VAL_MAX)};
    end
    return {1'b0, sh[W-1:0]};
  endfunction

  function automatic logic [W:0] sum_sat(logic signed [W-1:0] a, logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] ^ s[W-1]) begin
      return {1'b1, (s[W] ? bgemv_pkg::VAL_MIN : bgemv_pkg::VAL_MAX)};
    end
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [AW-1:0] band_addr(logic [IW-1:0] i, logic [IW-1:0] j);
    return AW'(j * bgemv_pkg::BAND_STRIDE) + AW'(i) + AW'(bgemv_pkg::MAX_SUPER_DIAG);
  endfunction

  // configuration
  logic [NW-1:0]        size_q;
  logic [DW-1:0]        kl_q, ku_q;
  logic signed [W-1:0]  alpha_q, beta_q;

  // control and result path
  state_e               state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  bgemv_pkg::res_t      out_res_q, out_res_d;
  logic                 pend_q, pend_d;
  bgemv_pkg::res_t      pend_res_q, pend_res_d;
  logic                 flag_q, flag_d;

  // datapath
  logic [IW-1:0]        idx_q, idx_d;
  logic [IW-1:0]        j_q, j_d;
  logic signed [W-1:0]  t_q, t_d;
  logic signed [PW-1:0] prod_q;
  logic signed [W-1:0]  mul_a, mul_b;

  logic                 deliver;
  bgemv_pkg::res_t      dres;
  logic                 slot_free;
  logic                 accept;

  logic [NW-1:0]        n_eff, n_m1, end_row, j_kl;
  logic [DW-1:0]        kl_eff, ku_eff;
  logic [IW-1:0]        first_row;
  logic                 row_ok, col_ok, band_ok;
  logic [W:0]           psat, ssat;
  logic                 last_col;

  // memory ports
  logic                 band_we, x_we, y_we;
  logic [AW-1:0]        band_waddr, band_raddr;
  logic [IW-1:0]        y_waddr, y_raddr;
  logic [W-1:0]         band_rdata, x_rdata, y_rdata, y_wdata;

  bgemv_ram #(.WIDTH(W), .DEPTH(bgemv_pkg::BAND_DEPTH)) u_band_ram (
    .clk_i   (clk_i),
    .we_i    (band_we),
    .waddr_i (band_waddr),
    .wdata_i (in_i.write_value),
    .raddr_i (band_raddr),
    .rdata_o (band_rdata)
  );

  bgemv_ram #(.WIDTH(W), .DEPTH(bgemv_pkg::MAX_ORDER)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (in_i.row_index),
    .wdata_i (in_i.write_value),
    .raddr_i (j_q),
    .rdata_o (x_rdata)
  );

  bgemv_ram #(.WIDTH(W), .DEPTH(bgemv_pkg::MAX_ORDER)) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (y_waddr),
    .wdata_i (y_wdata),
    .raddr_i (y_raddr),
    .rdata_o (y_rdata)
  );

  // effective sizes and band limits
  assign n_eff  = (size_q > NW'(bgemv_pkg::MAX_ORDER)) ? NW'(bgemv_pkg::MAX_ORDER) : size_q;
  assign kl_eff = (kl_q > DW'(bgemv_pkg::MAX_SUB_DIAG)) ? DW'(bgemv_pkg::MAX_SUB_DIAG) : kl_q;
  assign ku_eff = (ku_q > DW'(bgemv_pkg::MAX_SUPER_DIAG)) ? DW'(bgemv_pkg::MAX_SUPER_DIAG) : ku_q;
  assign n_m1   = n_eff - NW'(1);

  assign j_kl      = {1'b0, j_q} + NW'(kl_eff);
  assign end_row   = (j_kl < n_m1) ? j_kl : n_m1;
  assign first_row = ({1'b0, j_q} > NW'(ku_eff)) ? (j_q - IW'(ku_eff)) : '0;
  assign last_col  = ({1'b0, j_q} == n_m1);

  assign row_ok  = {1'b0, in_i.row_index} < n_eff;
  assign col_ok  = {1'b0, in_i.col_index} < n_eff;
  assign band_ok = row_ok && col_ok
                && ({1'b0, in_i.col_index} <= {1'b0, in_i.row_index} + NW'(ku_eff))
                && ({1'b0, in_i.row_index} <= {1'b0, in_i.col_index} + NW'(kl_eff));

  assign band_waddr = band_addr(in_i.row_index, in_i.col_index);
  assign band_raddr = band_addr(idx_q, j_q);
  assign y_raddr    = (state_q == S_IDLE) ? in_i.row_index : idx_q;

  assign psat = prod_sat(prod_q);
  assign ssat = sum_sat(y_rdata, psat[W-1:0]);

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      S_B_MUL: begin
        mul_a = y_rdata;
        mul_b = beta_q;
      end
      S_X_CHK: begin
        mul_a = alpha_q;
        mul_b = x_rdata;
      end
      default: begin
        mul_a = band_rdata;
        mul_b = t_q;
      end
    endcase
  end

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE) && !pend_q;
  assign cfg_i.ready = 1'b1;
  assign slot_free   = !out_valid_q || res_o.ready;

  assign res_o.valid      = out_valid_q;
  assign res_o.read_value = out_res_q.read_value;
  assign res_o.error_code = out_res_q.error_code;

  // sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    j_d     = j_q;
    t_d     = t_q;
    flag_d  = flag_q;
    deliver = 1'b0;
    dres    = '{read_value: '0, error_code: bgemv_pkg::ERR_OK};
    band_we = 1'b0;
    x_we    = 1'b0;
    y_we    = 1'b0;
    y_waddr = idx_q;
    y_wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        y_waddr = in_i.row_index;
        y_wdata = in_i.write_value;
        if (accept) begin
          unique case (bgemv_pkg::op_e'(in_i.operation))
            bgemv_pkg::OP_WR_BAND: begin
              band_we = band_ok;
              deliver = 1'b1;
              dres.error_code = band_ok ? bgemv_pkg::ERR_OK : bgemv_pkg::ERR_ADDR;
            end
            bgemv_pkg::OP_WR_X: begin
              x_we    = row_ok;
              deliver = 1'b1;
              dres.error_code = row_ok ? bgemv_pkg::ERR_OK : bgemv_pkg::ERR_ADDR;
            end
            bgemv_pkg::OP_WR_Y: begin
              y_we    = row_ok;
              deliver = 1'b1;
              dres.error_code = row_ok ? bgemv_pkg::ERR_OK : bgemv_pkg::ERR_ADDR;
            end
            bgemv_pkg::OP_COMPUTE: begin
              flag_d = 1'b0;
              idx_d  = '0;
              j_d    = '0;
              if (n_eff == '0) begin
                deliver = 1'b1;
                dres.error_code = bgemv_pkg::ERR_ADDR;
              end else if (beta_q == '0) begin
                state_d = S_B_CLR;
              end else if (beta_q == bgemv_pkg::ONE_Q) begin
                state_d = S_X_RD;
              end else begin
                state_d = S_B_RD;
              end
            end
            bgemv_pkg::OP_RD_Y: begin
              if (row_ok) begin
                state_d = S_RD_WAIT;
              end else begin
                deliver = 1'b1;
                dres.error_code = bgemv_pkg::ERR_ADDR;
              end
            end
            default: begin
              deliver = 1'b1;
            end
          endcase
        end
      end

      S_RD_WAIT: begin
        deliver = 1'b1;
        dres.read_value = y_rdata;
        state_d = S_IDLE;
      end

      S_B_CLR: begin
        y_we = 1'b1;
        if ({1'b0, idx_q} == n_m1) begin
          state_d = S_X_RD;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      S_B_RD: begin
        state_d = S_B_MUL;
      end

      S_B_MUL: begin
        state_d = S_B_WR;
      end

      S_B_WR: begin
        y_we    = 1'b1;
        y_wdata = psat[W-1:0];
        flag_d  = flag_q | psat[W];
        if ({1'b0, idx_q} == n_m1) begin
          state_d = S_X_RD;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_B_RD;
        end
      end

      S_X_RD: begin
        state_d = S_X_CHK;
      end

      S_X_CHK: begin
        // skip a column whose x element is zero
        if (x_rdata == '0) begin
          if (last_col) begin
            state_d = S_FIN;
          end else begin
            j_d     = j_q + IW'(1);
            state_d = S_X_RD;
          end
        end else begin
          state_d = S_T_SAT;
        end
      end

      S_T_SAT: begin
        t_d     = psat[W-1:0];
        flag_d  = flag_q | psat[W];
        idx_d   = first_row;
        state_d = S_A_RD;
      end

      S_A_RD: begin
        state_d = S_A_MUL;
      end

      S_A_MUL: begin
        state_d = S_A_WR;
      end

      S_A_WR: begin
        y_we    = 1'b1;
        y_wdata = ssat[W-1:0];
        flag_d  = flag_q | psat[W] | ssat[W];
        if ({1'b0, idx_q} == end_row) begin
          if (last_col) begin
            state_d = S_FIN;
          end else begin
            j_d     = j_q + IW'(1);
            state_d = S_X_RD;
          end
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_A_RD;
        end
      end

      S_FIN: begin
        deliver = 1'b1;
        dres.error_code = flag_q ? bgemv_pkg::ERR_SAT : bgemv_pkg::ERR_OK;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register with one pending slot behind it
  always_comb begin
    out_valid_d = out_valid_q && !res_o.ready;
    out_res_d   = out_res_q;
    pend_d      = pend_q;
    pend_res_d  = pend_res_q;
    if (pend_q && slot_free) begin
      out_valid_d = 1'b1;
      out_res_d   = pend_res_q;
      pend_d      = 1'b0;
    end else if (deliver) begin
      if (slot_free) begin
        out_valid_d = 1'b1;
        out_res_d   = dres;
      end else begin
        pend_d     = 1'b1;
        pend_res_d = dres;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_res_q   <= '{read_value: '0, error_code: bgemv_pkg::ERR_OK};
      pend_q      <= 1'b0;
      pend_res_q  <= '{read_value: '0, error_code: bgemv_pkg::ERR_OK};
      flag_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
      pend_q      <= pend_d;
      pend_res_q  <= pend_res_d;
      flag_q      <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    j_q    <= j_d;
    t_q    <= t_d;
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= NW'(1);
      kl_q    <= '0;
      ku_q    <= '0;
      alpha_q <= bgemv_pkg::ONE_Q;
      beta_q  <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (bgemv_pkg::cfg_e'(cfg_i.index))
        bgemv_pkg::CFG_SIZE:  size_q  <= cfg_i.data[NW-1:0];
        bgemv_pkg::CFG_SUB:   kl_q    <= cfg_i.data[DW-1:0];
        bgemv_pkg::CFG_SUPER: ku_q    <= cfg_i.data[DW-1:0];
        bgemv_pkg::CFG_ALPHA: alpha_q <= cfg_i.data[W-1:0];
        bgemv_pkg::CFG_BETA:  beta_q  <= cfg_i.data[W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: bench/banded_matrix_vector_gemv_core_tb.sv
// Self-checking bench for the banded y = alpha*A*x + beta*y core: directed table, then
// randomized phases over several band shapes and gains. Depends on bgemv_pkg, bgemv_if and the core.
module banded_matrix_vector_gemv_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bgemv_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [VALUE_W-1:0] val;
    bit                        typed;
    res_t                      want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  bgemv_in_if  cmd_if ();
  bgemv_cfg_if cfg_if ();
  bgemv_out_if res_if ();

  banded_matrix_vector_gemv_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // Shadow copy of the core: configuration, memories and which entries hold data.
  logic [N_W-1:0]            n_reg;
  logic [DIAG_W-1:0]         kl_reg;
  logic [DIAG_W-1:0]         ku_reg;
  logic signed [VALUE_W-1:0] alpha_reg;
  logic signed [VALUE_W-1:0] beta_reg;
  logic signed [VALUE_W-1:0] band_mem [BAND_DEPTH];
  logic signed [VALUE_W-1:0] x_mem    [MAX_ORDER];
  logic signed [VALUE_W-1:0] y_mem    [MAX_ORDER];
  bit                        band_wr  [BAND_DEPTH];
  bit                        x_wr     [MAX_ORDER];
  bit                        y_wr     [MAX_ORDER];
  bit                        sat_hit;

  res_t     pending_words [$];
  dir_row_t dir_rows [$];

  int mismatches    = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int products_run  = 0;
  int sat_words     = 0;
  int addr_words    = 0;
  int settings_used = 0;
  int burst_left    = 8;
  int x_zero_pct    = 20;
  int compute_pct   = 6;
  int stall_mode    = 0;
  int stall_left    = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10ms;
    $display("banded_matrix_vector_gemv_core_tb: FAIL");
    $finish;
  end

  // Result side stalls in modes of random length: open, coin flip, mostly closed, periodic.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       res_if.ready <= 1'b1;
      1:       res_if.ready <= ($urandom_range(0, 1) != 0);
      2:       res_if.ready <= ($urandom_range(0, 4) == 0);
      default: res_if.ready <= ((stall_left % 5) != 0);
    endcase
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_words.size() == 0) begin
        flag_mismatch($sformatf("result word %0d with nothing pending (value %h code %0d)",
                                words_checked, res_if.read_value, res_if.error_code));
      end else begin
        want = pending_words.pop_front();
        if (res_if.read_value !== want.read_value)
          flag_mismatch($sformatf("word %0d read_value %h, want %h", words_checked,
                                  res_if.read_value, want.read_value));
        if (res_if.error_code !== want.error_code)
          flag_mismatch($sformatf("word %0d error_code %0d, want %0d", words_checked,
                                  res_if.error_code, want.error_code));
      end
      words_checked++;
    end
  end

  function automatic int eff_order();
    return (n_reg > MAX_ORDER) ? MAX_ORDER : int'(n_reg);
  endfunction

  function automatic int eff_sub();
    return (kl_reg > MAX_SUB_DIAG) ? MAX_SUB_DIAG : int'(kl_reg);
  endfunction

  function automatic int eff_super();
    return (ku_reg > MAX_SUPER_DIAG) ? MAX_SUPER_DIAG : int'(ku_reg);
  endfunction

  function automatic int band_slot(int i, int j);
    return j * BAND_ROWS + i + MAX_SUPER_DIAG - j;
  endfunction

  function automatic logic signed [VALUE_W-1:0] clamp_q(longint v);
    if (v > longint'(VAL_MAX)) begin
      sat_hit = 1'b1;
      return VAL_MAX;
    end
    if (v < longint'(VAL_MIN)) begin
      sat_hit = 1'b1;
      return VAL_MIN;
    end
    return v[VALUE_W-1:0];
  endfunction

  // Full product, floor shift by the fraction width, then clamp.
  function automatic logic signed [VALUE_W-1:0] q_mul(logic signed [VALUE_W-1:0] a,
                                                     logic signed [VALUE_W-1:0] b);
    longint full;
    full = longint'(a) * longint'(b);
    return clamp_q(full >>> FRAC_W);
  endfunction

  function automatic err_e run_product();
    int n, kl, ku, first, last;
    logic signed [VALUE_W-1:0] scaled_x, term;
    n = eff_order();
    kl = eff_sub();
    ku = eff_super();
    if (n == 0) return ERR_ADDR;
    sat_hit = 1'b0;
    if (beta_reg == 0) begin
      for (int i = 0; i < n; i++) begin
        y_mem[i] = '0;
        y_wr[i] = 1'b1;
      end
    end else if (beta_reg != ONE_Q) begin
      for (int i = 0; i < n; i++) y_mem[i] = q_mul(y_mem[i], beta_reg);
    end
    for (int j = 0; j < n; j++) begin
      if (x_mem[j] != 0) begin
        scaled_x = q_mul(alpha_reg, x_mem[j]);
        first = (j > ku) ? j - ku : 0;
        last = (j + kl < n - 1) ? j + kl : n - 1;
        for (int i = first; i <= last; i++) begin
          term = q_mul(band_mem[band_slot(i, j)], scaled_x);
          y_mem[i] = clamp_q(longint'(y_mem[i]) + longint'(term));
        end
      end
    end
    return sat_hit ? ERR_SAT : ERR_OK;
  endfunction

  function automatic res_t gemv_outcome(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                                        logic [IDX_W-1:0] col, logic signed [VALUE_W-1:0] val);
    res_t r;
    int n, i, j;
    n = eff_order();
    i = int'(row);
    j = int'(col);
    r.read_value = '0;
    r.error_code = ERR_OK;
    case (op)
      OP_WR_BAND: begin
        if (i < n && j < n && j <= i + eff_super() && i <= j + eff_sub()) begin
          band_mem[band_slot(i, j)] = val;
          band_wr[band_slot(i, j)] = 1'b1;
        end else begin
          r.error_code = ERR_ADDR;
        end
      end
      OP_WR_X: begin
        if (i < n) begin
          x_mem[i] = val;
          x_wr[i] = 1'b1;
        end else begin
          r.error_code = ERR_ADDR;
        end
      end
      OP_WR_Y: begin
        if (i < n) begin
          y_mem[i] = val;
          y_wr[i] = 1'b1;
        end else begin
          r.error_code = ERR_ADDR;
        end
      end
      OP_COMPUTE: r.error_code = run_product();
      OP_RD_Y: begin
        if (i < n) r.read_value = y_mem[i];
        else r.error_code = ERR_ADDR;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Finds an entry that a product would read before it was ever written: x, then y, then band.
  function automatic bit first_missing(output logic [OP_W-1:0] op, output logic [IDX_W-1:0] row,
                                       output logic [IDX_W-1:0] col);
    int n, kl, ku;
    n = eff_order();
    kl = eff_sub();
    ku = eff_super();
    op = OP_WR_X;
    row = '0;
    col = '0;
    for (int j = 0; j < n; j++) begin
      if (!x_wr[j]) begin
        op = OP_WR_X;
        row = IDX_W'(j);
        return 1'b1;
      end
    end
    if (beta_reg != 0) begin
      for (int i = 0; i < n; i++) begin
        if (!y_wr[i]) begin
          op = OP_WR_Y;
          row = IDX_W'(i);
          return 1'b1;
        end
      end
    end
    for (int j = 0; j < n; j++) begin
      if (x_mem[j] != 0) begin
        for (int i = (j > ku ? j - ku : 0); i <= (j + kl < n - 1 ? j + kl : n - 1); i++) begin
          if (!band_wr[band_slot(i, j)]) begin
            op = OP_WR_BAND;
            row = IDX_W'(i);
            col = IDX_W'(j);
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value(int zero_pct);
    int pick, s;
    pick = $urandom_range(0, 99);
    if (pick < zero_pct) return '0;
    pick = $urandom_range(0, 99);
    if (pick < 3) return VAL_MAX;
    if (pick < 6) return VAL_MIN;
    if (pick < 10) return ($urandom_range(0, 1) != 0) ? ONE_Q : -ONE_Q;
    if (pick < 75) begin
      s = $urandom_range(0, 1 << 27);
      return s - (1 << 26);
    end
    return $urandom();
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_gain();
    int pick, s;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return '0;
      1: return ONE_Q;
      2: return -ONE_Q;
      3: return VAL_MAX;
      4: return VAL_MIN;
      8, 9: return $urandom();
      default: begin
        s = $urandom_range(0, 1 << 26);
        return s - (1 << 25);
      end
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int n;
    n = eff_order();
    if (n > 0 && $urandom_range(0, 4) != 0) return IDX_W'($urandom_range(0, n - 1));
    return IDX_W'($urandom_range(0, MAX_ORDER - 1));
  endfunction

  function automatic dir_row_t dir_entry(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                                         logic [IDX_W-1:0] col, logic signed [VALUE_W-1:0] val,
                                         bit typed, logic signed [VALUE_W-1:0] rv, err_e ec);
    dir_row_t d;
    d.op = op;
    d.row = row;
    d.col = col;
    d.val = val;
    d.typed = typed;
    d.want.read_value = rv;
    d.want.error_code = ec;
    return d;
  endfunction

  // Hold the word until taken, then update the shadow state.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic signed [VALUE_W-1:0] val,
                           output res_t predicted);
    cmd_if.valid       <= 1'b1;
    cmd_if.operation   <= op;
    cmd_if.row_index   <= row;
    cmd_if.col_index   <= col;
    cmd_if.write_value <= val;
    do @(posedge clk_i); while (!cmd_if.ready);
    predicted = gemv_outcome(op, row, col, val);
    words_sent++;
    if (op == OP_COMPUTE) products_run++;
    if (predicted.error_code == ERR_SAT) sat_words++;
    if (predicted.error_code == ERR_ADDR) addr_words++;
  endtask

  // Bursts with random gaps; now and then drain every pending result first.
  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      if ($urandom_range(0, 39) == 0) begin
        while (pending_words.size() != 0) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
    end
  endtask

  task automatic issue(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                       input logic [IDX_W-1:0] col, input logic signed [VALUE_W-1:0] val);
    res_t predicted;
    send_word(op, row, col, val, predicted);
    pending_words.push_back(predicted);
    pace();
  endtask

  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_SIZE:  n_reg = data[N_W-1:0];
      CFG_SUB:   kl_reg = data[DIAG_W-1:0];
      CFG_SUPER: ku_reg = data[DIAG_W-1:0];
      CFG_ALPHA: alpha_reg = data;
      CFG_BETA:  beta_reg = data;
      default: ;
    endcase
  endtask

  task automatic random_item(output logic [OP_W-1:0] op, output logic [IDX_W-1:0] row,
                             output logic [IDX_W-1:0] col, output logic signed [VALUE_W-1:0] val);
    int n, kl, ku, pick, i, j, d;
    n = eff_order();
    kl = eff_sub();
    ku = eff_super();
    pick = $urandom_range(0, 99);
    row = IDX_W'($urandom());
    col = IDX_W'($urandom());
    val = pick_value(10);
    if (pick < 30) begin
      op = OP_WR_BAND;
      if (n > 0 && $urandom_range(0, 4) != 0) begin
        j = $urandom_range(0, n - 1);
        d = $urandom_range(0, kl + ku);
        i = j - ku + d;
        if (i < 0) i = 0;
        if (i > n - 1) i = n - 1;
        row = IDX_W'(i);
        col = IDX_W'(j);
      end
    end else if (pick < 45) begin
      op = OP_WR_X;
      row = pick_index();
      val = pick_value(x_zero_pct);
    end else if (pick < 57) begin
      op = OP_WR_Y;
      row = pick_index();
    end else if (pick < 57 + compute_pct) begin
      op = OP_COMPUTE;
    end else if (pick < 62 + compute_pct) begin
      op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    end else begin
      op = OP_RD_Y;
      row = pick_index();
    end
  endtask

  task automatic run_phase(input logic [N_W-1:0] n, input logic [DIAG_W-1:0] kl,
                           input logic [DIAG_W-1:0] ku, input logic signed [VALUE_W-1:0] alpha,
                           input logic signed [VALUE_W-1:0] beta, input int count,
                           input int zero_pct, input int cpct, input bit junk);
    logic [OP_W-1:0]           op, fop;
    logic [IDX_W-1:0]          row, col, frow, fcol;
    logic signed [VALUE_W-1:0] val;
    logic [CFG_DATA_W-1:0]     pad_n, pad_d;
    settle();
    // Upper bits beyond each register's width must be dropped by the core.
    pad_n = junk ? ($urandom() & 32'hFFFF_F800) : '0;
    pad_d = junk ? ($urandom() & 32'hFFFF_FFF8) : '0;
    write_reg(CFG_SIZE, pad_n | CFG_DATA_W'(n));
    write_reg(CFG_SUB, pad_d | CFG_DATA_W'(kl));
    write_reg(CFG_SUPER, pad_d | CFG_DATA_W'(ku));
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_BETA, beta);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    x_zero_pct = zero_pct;
    compute_pct = cpct;
    settings_used++;
    // Fill the operands of a product only when this phase runs products.
    if (cpct > 0) begin
      while (first_missing(op, row, col))
        issue(op, row, col, pick_value(op == OP_WR_X ? x_zero_pct : 10));
    end
    repeat (count) begin
      random_item(op, row, col, val);
      // Never let a read or a product touch an entry that holds no data yet.
      if (op == OP_RD_Y && row < eff_order() && !y_wr[row]) begin
        op = OP_WR_Y;
      end else if (op == OP_COMPUTE && first_missing(fop, frow, fcol)) begin
        op = fop;
        row = frow;
        col = fcol;
        val = pick_value(op == OP_WR_X ? x_zero_pct : 10);
      end
      issue(op, row, col, val);
    end
  endtask

  initial begin : stimulus
    res_t predicted;
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.operation   = OP_WR_BAND;
    cmd_if.row_index   = '0;
    cmd_if.col_index   = '0;
    cmd_if.write_value = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_SIZE;
    cfg_if.data        = '0;
    res_if.ready       = 1'b0;
    n_reg     = 11'd1;
    kl_reg    = '0;
    ku_reg    = '0;
    alpha_reg = ONE_Q;
    beta_reg  = '0;

    // Reset settings: order one, diagonal only, alpha 1.0, beta 0.
    dir_rows.push_back(dir_entry(OP_WR_Y, 10'd0, 10'd0, VAL_MAX, 1, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_RD_Y, 10'd0, 10'd0, '0, 1, VAL_MAX, ERR_OK));
    dir_rows.push_back(dir_entry(OP_WR_Y, 10'd0, 10'd0, VAL_MIN, 1, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_RD_Y, 10'd0, 10'd0, '0, 1, VAL_MIN, ERR_OK));
    dir_rows.push_back(dir_entry(OP_WR_Y, 10'd1023, 10'd1023, -1, 1, '0, ERR_ADDR));
    dir_rows.push_back(dir_entry(OP_RD_Y, 10'd1023, 10'd0, '0, 1, '0, ERR_ADDR));
    dir_rows.push_back(dir_entry(OP_WR_X, 10'd1, 10'd0, ONE_Q, 1, '0, ERR_ADDR));
    dir_rows.push_back(dir_entry(OP_WR_BAND, 10'd0, 10'd1, ONE_Q, 1, '0, ERR_ADDR));
    dir_rows.push_back(dir_entry(OP_WR_BAND, 10'd1023, 10'd1023, VAL_MAX, 1, '0, ERR_ADDR));
    dir_rows.push_back(dir_entry(OP_WR_BAND, 10'd0, 10'd0, VAL_MAX, 1, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_WR_X, 10'd0, 10'd0, ONE_Q, 1, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_COMPUTE, 10'd0, 10'd0, '0, 0, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_RD_Y, 10'd0, 10'd0, '0, 0, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_SPARE_A, 10'd1023, 10'd1023, -1, 1, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_SPARE_B, 10'd0, 10'd0, VAL_MAX, 1, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_SPARE_C, 10'd512, 10'd511, VAL_MIN, 1, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_WR_X, 10'd0, 10'd0, VAL_MAX, 1, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_COMPUTE, 10'd0, 10'd0, '0, 0, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_RD_Y, 10'd0, 10'd0, '0, 0, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_WR_BAND, 10'd0, 10'd0, VAL_MIN, 1, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_COMPUTE, 10'd0, 10'd0, '0, 0, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_RD_Y, 10'd0, 10'd0, '0, 0, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_WR_X, 10'd0, 10'd0, '0, 1, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_COMPUTE, 10'd0, 10'd0, '0, 0, '0, ERR_OK));
    dir_rows.push_back(dir_entry(OP_RD_Y, 10'd0, 10'd0, '0, 0, '0, ERR_OK));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      send_word(dir_rows[k].op, dir_rows[k].row, dir_rows[k].col, dir_rows[k].val, predicted);
      pending_words.push_back(dir_rows[k].typed ? dir_rows[k].want : predicted);
      pace();
    end

    run_phase(11'd8, 3'd1, 3'd1, ONE_Q, '0, 250, 20, 6, 1'b0);
    run_phase(11'd16, 3'd4, 3'd4, 32'sh0080_0000, ONE_Q, 250, 20, 6, 1'b0);
    run_phase(11'd0, 3'd2, 3'd3, pick_gain(), pick_gain(), 40, 20, 10, 1'b1);
    run_phase(11'd5, 3'd0, 3'd4, -ONE_Q, 32'shFF40_0000, 200, 20, 6, 1'b0);
    run_phase(11'd1, 3'd4, 3'd0, VAL_MAX, VAL_MIN, 100, 10, 10, 1'b0);
    run_phase(11'd12, 3'd6, 3'd7, VAL_MIN, VAL_MAX, 150, 20, 6, 1'b1);
    // Oversized order and diagonals: writes, reads and unused operation codes only, so x needs no fill.
    run_phase(11'd2047, 3'd7, 3'd5, ONE_Q, '0, 100, 97, 0, 1'b0);
    repeat (8)
      run_phase(N_W'($urandom_range(1, 20)), DIAG_W'($urandom_range(0, 7)),
                DIAG_W'($urandom_range(0, 7)), pick_gain(), pick_gain(), 85, 25, 6,
                1'($urandom_range(0, 1)));

    settle();
    repeat (40) @(posedge clk_i);

    $display("covered %0d command words over %0d register settings plus reset defaults",
             words_sent, settings_used);
    $display("%0d products (%0d saturating), %0d address errors, %0d result words checked",
             products_run, sat_words, addr_words, words_checked);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("banded_matrix_vector_gemv_core_tb: PASS");
    end else begin
      $display("banded_matrix_vector_gemv_core_tb: FAIL");
    end
    $finish;
  end

endmodule
